/* hdl/fat_cluster_chain_addresser_unit_defines.svh */
// assertion macros shared by the chain addresser modules
`ifndef FAT_CLUSTER_CHAIN_ADDRESSER_UNIT_DEFINES_SVH
`define FAT_CLUSTER_CHAIN_ADDRESSER_UNIT_DEFINES_SVH

// same-cycle implication
`define FCCA_ASSERT_HOLDS(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FCCA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/fcca_pkg.sv */
package fcca_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int BPS_W      = 13;
  localparam int SPC_W      = 8;
  localparam int RSV_W      = 16;
  localparam int FCNT_W     = 8;
  localparam int REC_W      = 16;
  localparam int CL_W       = 28;
  localparam int OFF_W      = CL_W + 2;
  localparam int SEC_W      = 32;
  localparam int FOFF_W     = 12;
  localparam int RDS_W      = 22;
  localparam int DIV_STEPS  = 32;
  localparam int DCNT_W     = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_SECTOR    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECTORS_PER_CLUSTER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESERVED_SECTORS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FAT_COUNT           = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FAT_SIZE_SECTORS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROOT_ENTRY_COUNT    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_SECTOR_COUNT  = 3'd6;

  localparam logic [BPS_W-1:0]  RST_BYTES_PER_SECTOR    = 13'd512;
  localparam logic [SPC_W-1:0]  RST_SECTORS_PER_CLUSTER = 8'd1;
  localparam logic [RSV_W-1:0]  RST_RESERVED_SECTORS    = 16'd32;
  localparam logic [FCNT_W-1:0] RST_FAT_COUNT           = 8'd2;
  localparam logic [31:0]       RST_FAT_SIZE_SECTORS    = 32'd1;
  localparam logic [REC_W-1:0]  RST_ROOT_ENTRY_COUNT    = 16'd0;
  localparam logic [31:0]       RST_TOTAL_SECTOR_COUNT  = 32'd0;

  localparam logic [1:0] KIND_MEMBER = 2'd0;
  localparam logic [1:0] KIND_END    = 2'd1;
  localparam logic [1:0] KIND_BAD    = 2'd2;

  localparam logic [1:0] FAT_KIND_12 = 2'd0;
  localparam logic [1:0] FAT_KIND_16 = 2'd1;
  localparam logic [1:0] FAT_KIND_32 = 2'd2;

  localparam logic [31:0] END_MARK        = 32'h0FFF_FFF8;
  localparam logic [31:0] BAD_MARK        = 32'h0FFF_FFF7;
  localparam logic [31:0] FAT12_LIMIT     = 32'd4085;
  localparam logic [31:0] FAT16_LIMIT     = 32'd65525;
  localparam int          DIR_ENTRY_SHIFT = 5;

  typedef struct packed {
    logic        action;
    logic [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [CL_W-1:0]   cluster;
    logic [SEC_W-1:0]  data_sector;
    logic [SEC_W-1:0]  fat_sector;
    logic [FOFF_W-1:0] fat_byte_offset;
    logic [1:0]        fat_kind;
  } out_item_t;

  typedef struct packed {
    logic              busy;
    logic [BPS_W-1:0]  divisor;
    logic [SPC_W-1:0]  spc;
    logic [RSV_W-1:0]  reserved;
    logic [SEC_W-1:0]  first_data;
    logic [1:0]        fat_kind;
  } geom_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [CL_W-1:0]  cluster;
    logic [SEC_W-1:0] prod;
    logic [OFF_W-1:0] off;
    logic [1:0]       fat_kind;
  } q_item_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [CL_W-1:0]  cluster;
    logic [SEC_W-1:0] data_sector;
    logic [1:0]       fat_kind;
    logic [BPS_W-1:0] rem;
    logic [OFF_W-1:0] sh;
  } stage_t;

  typedef struct packed {
    logic [BPS_W-1:0] rem;
    logic             qbit;
  } div_step_t;

  // one restoring division step, remainder kept below the divisor
  function automatic div_step_t div_step(input logic [BPS_W-1:0] rem,
                                         input logic din,
                                         input logic [BPS_W-1:0] divisor);
    div_step_t res;
    logic [BPS_W:0] t;
    t = {rem, din};
    if (t >= {1'b0, divisor}) begin
      res.qbit = 1'b1;
      res.rem  = BPS_W'(t - {1'b0, divisor});
    end else begin
      res.qbit = 1'b0;
      res.rem  = t[BPS_W-1:0];
    end
    return res;
  endfunction

endpackage

/* hdl/fat_cluster_chain_addresser_unit.sv */
// FAT cluster chain addresser.
// Input channel: in_valid / in_stall / in_item (action, value). action 0 starts a
// chain at value, action 1 hands in the FAT word fetched for the previous item.
// Output channel: out_valid / out_stall / out_item, exactly one item per input,
// in input order: kind, cluster, first data sector, FAT sector and byte offset
// of the next entry to fetch, and the derived FAT type.
// Configuration: cfg_write_en / cfg_index / cfg_data, one register per cycle;
// must be written only while no item is in flight; the block does not enforce this.
// One item per cycle sustained while out_stall is low and the geometry is idle.
// An item passes through the queue, the 30-stage divider for the FAT offset
// and the output register.
// After reset and after every configuration write the geometry is recomputed
// on a shared iterative divider (two 32-step divisions) with in_stall held
// high; configuration writes are still taken during the recomputation.
// When out_valid and out_stall are both high the divider pipeline holds and
// the two-entry queue fills, then in_stall rises; nothing is dropped.
module fat_cluster_chain_addresser_unit
  import fcca_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item,
  input  logic                  cfg_write_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  geom_t   geom;
  q_item_t q_in;
  q_item_t q_out;
  logic    push;
  logic    pop;
  logic    q_full;
  logic    q_nonempty;

  fcca_geom u_geom (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .geom         (geom)
  );

  fcca_front u_front (
    .in_valid (in_valid),
    .in_item  (in_item),
    .geom     (geom),
    .q_full   (q_full),
    .in_stall (in_stall),
    .push     (push),
    .entry    (q_in)
  );

  fcca_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .entry_in  (q_in),
    .pop       (pop),
    .entry_out (q_out),
    .full      (q_full),
    .nonempty  (q_nonempty)
  );

  fcca_back u_back (
    .clk       (clk),
    .rst       (rst),
    .entry     (q_out),
    .nonempty  (q_nonempty),
    .geom      (geom),
    .out_stall (out_stall),
    .pop       (pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

/* hdl/fcca_geom.sv */
module fcca_geom
  import fcca_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output geom_t                 geom
);

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_RDS_LOAD = 7'b0000010,
    ST_RDS      = 7'b0000100,
    ST_MUL      = 7'b0001000,
    ST_ADD      = 7'b0010000,
    ST_CLU_LOAD = 7'b0100000,
    ST_CLU      = 7'b1000000
  } geom_state_t;

  geom_state_t         state;
  logic [BPS_W-1:0]    bps;
  logic [SPC_W-1:0]    spc;
  logic [RSV_W-1:0]    rsv;
  logic [FCNT_W-1:0]   fcnt;
  logic [31:0]         fsz;
  logic [REC_W-1:0]    rec;
  logic [31:0]         tot;
  logic [BPS_W-1:0]    dr;
  logic [31:0]         dq;
  logic [BPS_W-1:0]    dd;
  logic [DCNT_W-1:0]   dcnt;
  logic [RDS_W-1:0]    rds;
  logic [39:0]         prod;
  logic [40:0]         fdata;
  logic [1:0]          fk;

  logic [BPS_W-1:0]    bps_eff;
  logic [SPC_W-1:0]    spc_eff;
  div_step_t           step;
  logic [31:0]         dq_next;
  logic                last_step;
  logic [31:0]         data_cnt;

  assign bps_eff   = (bps == '0) ? BPS_W'(1) : bps;
  assign spc_eff   = (spc == '0) ? SPC_W'(1) : spc;
  assign step      = div_step(dr, dq[31], dd);
  assign dq_next   = {dq[30:0], step.qbit};
  assign last_step = (dcnt == DCNT_W'(DIV_STEPS - 1));
  assign data_cnt  = ({9'b0, tot} > fdata) ? (tot - fdata[31:0]) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RDS_LOAD;
      bps   <= RST_BYTES_PER_SECTOR;
      spc   <= RST_SECTORS_PER_CLUSTER;
      rsv   <= RST_RESERVED_SECTORS;
      fcnt  <= RST_FAT_COUNT;
      fsz   <= RST_FAT_SIZE_SECTORS;
      rec   <= RST_ROOT_ENTRY_COUNT;
      tot   <= RST_TOTAL_SECTOR_COUNT;
      fk    <= FAT_KIND_12;
    end else if (cfg_write_en) begin
      state <= ST_RDS_LOAD;
      case (cfg_index)
        REG_BYTES_PER_SECTOR:    bps  <= cfg_data[BPS_W-1:0];
        REG_SECTORS_PER_CLUSTER: spc  <= cfg_data[SPC_W-1:0];
        REG_RESERVED_SECTORS:    rsv  <= cfg_data[RSV_W-1:0];
        REG_FAT_COUNT:           fcnt <= cfg_data[FCNT_W-1:0];
        REG_FAT_SIZE_SECTORS:    fsz  <= cfg_data;
        REG_ROOT_ENTRY_COUNT:    rec  <= cfg_data[REC_W-1:0];
        REG_TOTAL_SECTOR_COUNT:  tot  <= cfg_data;
        default: ;
      endcase
    end else begin
      case (state)
        ST_IDLE: ;
        ST_RDS_LOAD: begin
          // ceiling of root directory bytes over sector size
          dq    <= {11'b0, rec, 5'b0} + {19'b0, bps_eff} - 32'd1;
          dr    <= '0;
          dd    <= bps_eff;
          dcnt  <= '0;
          state <= ST_RDS;
        end
        ST_RDS: begin
          dr   <= step.rem;
          dq   <= dq_next;
          dcnt <= dcnt + DCNT_W'(1);
          if (last_step) begin
            rds   <= dq_next[RDS_W-1:0];
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod  <= 40'(fsz) * 40'(fcnt);
          state <= ST_ADD;
        end
        ST_ADD: begin
          fdata <= 41'(rsv) + 41'(prod) + 41'(rds);
          state <= ST_CLU_LOAD;
        end
        ST_CLU_LOAD: begin
          dq    <= data_cnt;
          dr    <= '0;
          dd    <= BPS_W'(spc_eff);
          dcnt  <= '0;
          state <= ST_CLU;
        end
        ST_CLU: begin
          dr   <= step.rem;
          dq   <= dq_next;
          dcnt <= dcnt + DCNT_W'(1);
          if (last_step) begin
            if (dq_next < FAT12_LIMIT) begin
              fk <= FAT_KIND_12;
            end else if (dq_next < FAT16_LIMIT) begin
              fk <= FAT_KIND_16;
            end else begin
              fk <= FAT_KIND_32;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_RDS_LOAD;
      endcase
    end
  end

  assign geom.busy       = (state != ST_IDLE);
  assign geom.divisor    = bps_eff;
  assign geom.spc        = spc;
  assign geom.reserved   = rsv;
  assign geom.first_data = fdata[SEC_W-1:0];
  assign geom.fat_kind   = fk;

endmodule

/* hdl/fcca_front.sv */
module fcca_front
  import fcca_pkg::*;
(
  input  logic     in_valid,
  input  in_item_t in_item,
  input  geom_t    geom,
  input  logic     q_full,
  output logic     in_stall,
  output logic     push,
  output q_item_t  entry
);

  logic [31:0]     word;
  logic [CL_W-1:0] cl;

  assign in_stall = geom.busy || q_full;
  assign push     = in_valid && !in_stall;

  // a start cluster is classified on all 32 bits, a fetched word on 28
  assign cl   = in_item.value[CL_W-1:0];
  assign word = in_item.action ? {4'b0, cl} : in_item.value;

  always_comb begin
    if (word == BAD_MARK) begin
      entry.kind = KIND_BAD;
    end else if (word >= END_MARK) begin
      entry.kind = KIND_END;
    end else begin
      entry.kind = KIND_MEMBER;
    end
    entry.cluster  = cl;
    entry.fat_kind = geom.fat_kind;
    entry.prod     = (32'(cl) - 32'd2) * 32'(geom.spc);
    if (geom.fat_kind == FAT_KIND_16) begin
      entry.off = {1'b0, cl, 1'b0};
    end else begin
      entry.off = {cl, 2'b00};
    end
  end

endmodule

/* hdl/fcca_queue.sv */
`include "fat_cluster_chain_addresser_unit_defines.svh"

module fcca_queue
  import fcca_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  q_item_t entry_in,
  input  logic    pop,
  output q_item_t entry_out,
  output logic    full,
  output logic    nonempty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_item_t          slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign nonempty  = (count != '0);
  assign entry_out = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= entry_in;
    end
  end

  `FCCA_ASSERT_HOLDS(a_no_overflow, clk, rst, push, !full, "queue written while full")
  `FCCA_ASSERT_HOLDS(a_no_underflow, clk, rst, pop, nonempty, "queue read while empty")

endmodule

/* hdl/fcca_back.sv */
`include "fat_cluster_chain_addresser_unit_defines.svh"

module fcca_back
  import fcca_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  q_item_t   entry,
  input  logic      nonempty,
  input  geom_t     geom,
  input  logic      out_stall,
  output logic      pop,
  output logic      out_valid,
  output out_item_t out_item
);

  stage_t           p    [OFF_W+1];
  stage_t           nxt  [OFF_W];
  div_step_t        step [OFF_W];
  logic [OFF_W:0]   pv;
  logic             advance;
  stage_t           head;
  out_item_t        result;

  assign advance = !out_valid || !out_stall;
  assign pop     = advance && nonempty;

  always_comb begin
    head.kind        = entry.kind;
    head.cluster     = entry.cluster;
    head.data_sector = entry.prod + geom.first_data;
    head.fat_kind    = entry.fat_kind;
    head.rem         = '0;
    head.sh          = entry.off;
  end

  // one quotient bit per stage
  always_comb begin
    for (int k = 0; k < OFF_W; k++) begin
      step[k]       = div_step(p[k].rem, p[k].sh[OFF_W-1], geom.divisor);
      nxt[k]        = p[k];
      nxt[k].rem    = step[k].rem;
      nxt[k].sh     = {p[k].sh[OFF_W-2:0], step[k].qbit};
    end
  end

  always_comb begin
    result.kind     = p[OFF_W].kind;
    result.cluster  = p[OFF_W].cluster;
    result.fat_kind = p[OFF_W].fat_kind;
    if (p[OFF_W].kind == KIND_MEMBER) begin
      result.data_sector     = p[OFF_W].data_sector;
      result.fat_sector      = SEC_W'(geom.reserved) + SEC_W'(p[OFF_W].sh);
      result.fat_byte_offset = p[OFF_W].rem[FOFF_W-1:0];
    end else begin
      result.data_sector     = '0;
      result.fat_sector      = '0;
      result.fat_byte_offset = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv        <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      pv        <= {pv[OFF_W-1:0], nonempty};
      out_valid <= pv[OFF_W];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p[0] <= head;
      for (int k = 0; k < OFF_W; k++) begin
        p[k+1] <= nxt[k];
      end
      out_item <= result;
    end
  end

  `FCCA_ASSERT_NEXT(a_frozen_on_stall, clk, rst, out_valid && out_stall, $stable(pv),
    "pipeline moved while output stalled")
  `FCCA_ASSERT_NEXT(a_pop_enters, clk, rst, pop, pv[0], "popped item lost at pipeline entry")
  `FCCA_ASSERT_HOLDS(a_end_fields_zero, clk, rst,
    out_valid && (out_item.kind != KIND_MEMBER),
    (out_item.data_sector == '0) && (out_item.fat_sector == '0) && (out_item.fat_byte_offset == '0),
    "end or bad item carries sector fields")

endmodule

/* tb/fat_cluster_chain_addresser_unit_tb.sv */
module fat_cluster_chain_addresser_unit_tb;
  import fcca_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic [BPS_W-1:0]  bps;
    logic [SPC_W-1:0]  spc;
    logic [RSV_W-1:0]  rsv;
    logic [FCNT_W-1:0] fcnt;
    logic [31:0]       fsz;
    logic [REC_W-1:0]  rec;
    logic [31:0]       tot;
  } geometry_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  geometry_t vol;
  in_item_t fat_word_q[$];
  out_item_t cluster_addr_q[$];
  out_item_t want;
  bit steady = 1'b0;
  int send_gap = 0;
  int stall_left = 0;
  int sent_items = 0;
  int checked = 0;
  int errors = 0;
  int cycles = 0;
  int phases = 0;

  fat_cluster_chain_addresser_unit uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .cfg_write_en(cfg_write_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [63:0] first_data_sector_of(input geometry_t g);
    logic [63:0] bps;
    logic [63:0] rds;
    bps = (g.bps == 0) ? 64'd1 : 64'(g.bps);
    rds = ((64'(g.rec) << DIR_ENTRY_SHIFT) + bps - 64'd1) / bps;
    return 64'(g.rsv) + 64'(g.fcnt) * 64'(g.fsz) + rds;
  endfunction

  function automatic logic [1:0] fat_type_of(input geometry_t g);
    logic [63:0] fds;
    logic [63:0] data;
    logic [63:0] spc;
    logic [63:0] clusters;
    fds = first_data_sector_of(g);
    data = (64'(g.tot) > fds) ? 64'(g.tot) - fds : 64'd0;
    spc = (g.spc == 0) ? 64'd1 : 64'(g.spc);
    clusters = data / spc;
    if (clusters < 64'(FAT12_LIMIT)) return FAT_KIND_12;
    if (clusters < 64'(FAT16_LIMIT)) return FAT_KIND_16;
    return FAT_KIND_32;
  endfunction

  function automatic out_item_t locate_cluster(input geometry_t g, input in_item_t it);
    out_item_t r;
    logic [31:0] cl;
    logic [31:0] word;
    logic [63:0] fds;
    logic [63:0] bps;
    logic [63:0] off;
    cl = 32'(it.value[CL_W-1:0]);
    word = it.action ? cl : it.value;
    r.cluster = it.value[CL_W-1:0];
    r.fat_kind = fat_type_of(g);
    r.data_sector = '0;
    r.fat_sector = '0;
    r.fat_byte_offset = '0;
    if (word == BAD_MARK) begin
      r.kind = KIND_BAD;
    end else if (word >= END_MARK) begin
      r.kind = KIND_END;
    end else begin
      r.kind = KIND_MEMBER;
      fds = first_data_sector_of(g);
      bps = (g.bps == 0) ? 64'd1 : 64'(g.bps);
      off = (r.fat_kind == FAT_KIND_16) ? 64'(cl) * 64'd2 : 64'(cl) * 64'd4;
      r.data_sector = (cl - 32'd2) * 32'(g.spc) + fds[31:0];
      r.fat_sector = 32'(64'(g.rsv) + off / bps);
      r.fat_byte_offset = FOFF_W'(off % bps);
    end
    return r;
  endfunction

  function automatic int idle_cycles();
    if (steady) return 0;
    return ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(0, 19);
  endfunction

  function automatic void queue_item(input logic act, input logic [31:0] v);
    in_item_t it;
    it.action = act;
    it.value = v;
    fat_word_q = {fat_word_q, it};
  endfunction

  function automatic logic [CL_W-1:0] pick_cluster();
    case ($urandom_range(0, 7))
      0, 1, 2: return CL_W'($urandom_range(2, 200));
      3: return CL_W'($urandom_range(0, 1));
      4: return CL_W'($urandom_range(32'h0FFF_FFF0, 32'h0FFF_FFF6));
      default: return CL_W'($urandom_range(2, 32'h0FFF_FFF6));
    endcase
  endfunction

  // mostly start cluster, member words and a terminator; some cut short, some noise
  task automatic queue_chains(input int n);
    int made;
    int len;
    int j;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 9) < 7) begin
        len = $urandom_range(0, 8);
        queue_item(1'b0, {4'h0, pick_cluster()});
        made++;
        for (j = 0; j < len; j++) begin
          queue_item(1'b1, {4'($urandom), pick_cluster()});
          made++;
        end
        if ($urandom_range(0, 4) != 0) begin
          if ($urandom_range(0, 3) == 0)
            queue_item(1'b1, {4'($urandom), BAD_MARK[CL_W-1:0]});
          else
            queue_item(1'b1, {4'($urandom), 28'hFFF_FFF8 + 28'($urandom_range(0, 7))});
          made++;
        end
      end else begin
        case ($urandom_range(0, 3))
          0: queue_item(1'($urandom), $urandom);
          1: queue_item(1'b0, $urandom | 32'h1000_0000);
          2: queue_item(1'b0, BAD_MARK);
          default: queue_item(1'b1, {4'($urandom), 28'hFFF_FFF7 + 28'($urandom_range(0, 8))});
        endcase
        made++;
      end
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (fat_word_q.size() != 0 || in_valid || cluster_addr_q.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_BYTES_PER_SECTOR:    vol.bps = data[BPS_W-1:0];
      REG_SECTORS_PER_CLUSTER: vol.spc = data[SPC_W-1:0];
      REG_RESERVED_SECTORS:    vol.rsv = data[RSV_W-1:0];
      REG_FAT_COUNT:           vol.fcnt = data[FCNT_W-1:0];
      REG_FAT_SIZE_SECTORS:    vol.fsz = data;
      REG_ROOT_ENTRY_COUNT:    vol.rec = data[REC_W-1:0];
      REG_TOTAL_SECTOR_COUNT:  vol.tot = data;
      default: ;
    endcase
  endtask

  // dirty puts random junk above the width of each register narrower than 32 bits
  task automatic set_geometry(input geometry_t g, input bit dirty);
    logic [31:0] hi;
    hi = dirty ? $urandom : 32'd0;
    write_reg(REG_BYTES_PER_SECTOR, {hi[31:BPS_W], g.bps});
    write_reg(REG_SECTORS_PER_CLUSTER, {hi[31:SPC_W], g.spc});
    write_reg(REG_RESERVED_SECTORS, {hi[31:RSV_W], g.rsv});
    write_reg(REG_FAT_COUNT, {hi[31:FCNT_W], g.fcnt});
    write_reg(REG_FAT_SIZE_SECTORS, g.fsz);
    write_reg(REG_ROOT_ENTRY_COUNT, {hi[31:REC_W], g.rec});
    write_reg(REG_TOTAL_SECTOR_COUNT, g.tot);
    @(posedge clk);
    cfg_write_en <= 1'b0;
    phases++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        cluster_addr_q = {cluster_addr_q, locate_cluster(vol, in_item)};
        sent_items++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (fat_word_q.size() != 0) begin
          in_item <= fat_word_q.pop_front();
          in_valid <= 1'b1;
          send_gap = idle_cycles();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (cluster_addr_q.size() == 0) begin
          $error("result item with nothing pending: cluster %0h", out_item.cluster);
          errors++;
        end else begin
          want = cluster_addr_q.pop_front();
          if (out_item.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, out_item.kind);
            errors++;
          end
          if (out_item.cluster !== want.cluster) begin
            $error("cluster: expected %0h, got %0h", want.cluster, out_item.cluster);
            errors++;
          end
          if (out_item.data_sector !== want.data_sector) begin
            $error("data_sector: expected %0h, got %0h", want.data_sector,
                   out_item.data_sector);
            errors++;
          end
          if (out_item.fat_sector !== want.fat_sector) begin
            $error("fat_sector: expected %0h, got %0h", want.fat_sector, out_item.fat_sector);
            errors++;
          end
          if (out_item.fat_byte_offset !== want.fat_byte_offset) begin
            $error("fat_byte_offset: expected %0h, got %0h", want.fat_byte_offset,
                   out_item.fat_byte_offset);
            errors++;
          end
          if (out_item.fat_kind !== want.fat_kind) begin
            $error("fat_kind: expected %0d, got %0d", want.fat_kind, out_item.fat_kind);
            errors++;
          end
        end
        checked++;
        stall_left = idle_cycles();
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    geometry_t g;
    logic [63:0] fds;
    logic [63:0] spc1;
    logic [63:0] tot64;
    int unsigned type_bounds[4];
    int k;
    type_bounds = '{4084, 4085, 65524, 65525};
    vol = '{bps: RST_BYTES_PER_SECTOR, spc: RST_SECTORS_PER_CLUSTER,
            rsv: RST_RESERVED_SECTORS, fcnt: RST_FAT_COUNT, fsz: RST_FAT_SIZE_SECTORS,
            rec: RST_ROOT_ENTRY_COUNT, tot: RST_TOTAL_SECTOR_COUNT};
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset geometry: start values and fetched words at the marks
    queue_item(1'b0, 32'd2);
    queue_item(1'b0, 32'd0);
    queue_item(1'b0, 32'd1);
    queue_item(1'b0, 32'h0FFF_FFF6);
    queue_item(1'b0, BAD_MARK);
    queue_item(1'b0, END_MARK);
    queue_item(1'b0, 32'h0FFF_FFFF);
    queue_item(1'b0, 32'hFFFF_FFFF);
    queue_item(1'b0, 32'h1FFF_FFF7);
    queue_item(1'b0, 32'h1000_0005);
    queue_item(1'b1, 32'h0000_0003);
    queue_item(1'b1, 32'hF000_0003);
    queue_item(1'b1, 32'hFFFF_FFF7);
    queue_item(1'b1, END_MARK);
    queue_item(1'b1, 32'hFFFF_FFFF);
    queue_item(1'b1, 32'h0FFF_FFF6);
    queue_item(1'b1, 32'h0000_0000);
    queue_item(1'b1, 32'h0000_0001);
    queue_item(1'b1, 32'h1000_0000);
    queue_item(1'b1, 32'hAAAA_AAAA);
    queue_item(1'b1, 32'h5555_5555);
    wait_idle();

    // typical fat32
    g = '{bps: 13'd512, spc: 8'd8, rsv: 16'd32, fcnt: 8'd2, fsz: 32'd8192, rec: 16'd0,
          tot: 32'd8000000};
    set_geometry(g, 1'b0);
    queue_chains(100);
    wait_idle();

    // typical fat16, burst without idling
    g = '{bps: 13'd512, spc: 8'd4, rsv: 16'd1, fcnt: 8'd2, fsz: 32'd256, rec: 16'd512,
          tot: 32'd200000};
    set_geometry(g, 1'b0);
    steady = 1'b1;
    queue_chains(80);
    wait_idle();
    steady = 1'b0;

    // floppy sized fat12
    g = '{bps: 13'd512, spc: 8'd1, rsv: 16'd1, fcnt: 8'd2, fsz: 32'd9, rec: 16'd224,
          tot: 32'd2880};
    set_geometry(g, 1'b1);
    queue_chains(60);
    wait_idle();

    // smallest legal geometry
    g = '{bps: 13'd512, spc: 8'd1, rsv: 16'd1, fcnt: 8'd1, fsz: 32'd1, rec: 16'd0,
          tot: 32'd0};
    set_geometry(g, 1'b0);
    queue_chains(30);
    wait_idle();

    // largest geometry, metadata overflows 32 bits and the volume is too small
    g = '{bps: 13'd4096, spc: 8'd128, rsv: 16'hFFFF, fcnt: 8'hFF, fsz: 32'hFFFF_FFFF,
          rec: 16'hFFFF, tot: 32'hFFFF_FFFF};
    write_reg(REG_UNUSED, $urandom);
    set_geometry(g, 1'b0);
    queue_chains(40);
    wait_idle();

    // zero sector and cluster size
    g = '{bps: 13'd0, spc: 8'd0, rsv: 16'd1, fcnt: 8'd1, fsz: 32'd1, rec: 16'hFFFF,
          tot: 32'hFFFF_FFFF};
    set_geometry(g, 1'b1);
    queue_chains(40);
    wait_idle();

    // non power of two sector sizes
    g = '{bps: 13'h1FFF, spc: 8'd3, rsv: 16'd7, fcnt: 8'd1, fsz: 32'd100, rec: 16'd17,
          tot: 32'd1000000};
    set_geometry(g, 1'b0);
    queue_chains(30);
    wait_idle();
    g.bps = 13'd1000;
    g.tot = 32'd400000;
    set_geometry(g, 1'b0);
    queue_chains(30);
    wait_idle();

    // cluster counts either side of the fat type thresholds
    for (k = 0; k < 4; k++) begin
      g = '{bps: 13'd512, spc: 8'd1, rsv: 16'd1, fcnt: 8'd1, fsz: 32'd1, rec: 16'd0,
            tot: 32'd2 + type_bounds[k]};
      set_geometry(g, 1'b0);
      queue_chains(12);
      wait_idle();
    end

    // random geometries
    for (k = 0; k < 8; k++) begin
      g.bps = ($urandom_range(0, 3) != 0) ? BPS_W'(13'd512 << $urandom_range(0, 3))
                                          : BPS_W'($urandom);
      g.spc = ($urandom_range(0, 3) != 0) ? SPC_W'(1 << $urandom_range(0, 7))
                                          : SPC_W'($urandom);
      g.rsv = ($urandom_range(0, 3) != 0) ? RSV_W'($urandom_range(1, 64)) : RSV_W'($urandom);
      g.fcnt = ($urandom_range(0, 3) != 0) ? FCNT_W'($urandom_range(1, 2))
                                           : FCNT_W'($urandom);
      g.fsz = $urandom_range(1, 20000);
      g.rec = ($urandom_range(0, 1) != 0) ? '0 : REC_W'($urandom_range(0, 1024));
      g.tot = '0;
      fds = first_data_sector_of(g);
      spc1 = (g.spc == 0) ? 64'd1 : 64'(g.spc);
      case ($urandom_range(0, 3))
        0: tot64 = fds + 64'($urandom_range(0, 4084)) * spc1;
        1: tot64 = fds + 64'($urandom_range(4085, 65524)) * spc1;
        2: tot64 = fds + 64'($urandom_range(65525, 4000000)) * spc1;
        default: tot64 = fds >> 1;
      endcase
      if (k == 7 || tot64 > 64'hFFFF_FFFF) g.tot = $urandom;
      else g.tot = tot64[31:0];
      set_geometry(g, k[0]);
      steady = (k % 3 == 0);
      queue_chains(40);
      wait_idle();
    end
    steady = 1'b0;

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (cluster_addr_q.size() != 0) begin
      $error("%0d addressed results never arrived", cluster_addr_q.size());
      errors++;
    end
    $display("chain walk: %0d items sent, %0d results checked", sent_items, checked);
    $display("across %0d volume geometries incl. fat12/16/32, thresholds and zero sizes",
             phases + 1);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
